FILE: src/tcs_pkg.sv
// Package for the TCP checksum generator: item, state and result types,
// protocol constants and the end-around fold helpers. No dependencies.
package tcs_pkg;

    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned HDR_SUM_W   = 20;   // fifteen 16-bit words fit in 20 bits

    localparam logic [APB_ADDR_W-1:0] REG_LOCAL_ADDR = 3'd0;

    localparam logic [15:0] IP_PROTO_TCP      = 16'd6;
    localparam logic [15:0] TCP_HEADER_BYTES  = 16'd20;
    localparam logic [15:0] DATA_OFFSET_WORDS = 16'd5;
    localparam logic [15:0] NIBBLE_MASK       = 16'h000F;
    localparam logic [15:0] ODD_BYTE_MASK     = 16'hFF00;

    typedef enum logic {
        CMD_HEADER  = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_command;

    typedef struct packed {
        t_command    command;
        logic [31:0] dest_address;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  flag_bits;
        logic [15:0] window;
        logic [15:0] urgent_pointer;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [15:0] payload_word;
        logic        last_word;
    } t_item;

    typedef struct packed {
        logic [15:0] running_sum;
        logic        odd_length;
        logic        in_segment;
    } t_seg_state;

    typedef struct packed {
        logic        valid;
        logic [15:0] checksum;
    } t_result;

    // one end-around fold of a 17-bit sum
    function automatic logic [15:0] f_fold17(input logic [16:0] s);
        f_fold17 = s[15:0] + {15'd0, s[16]};
    endfunction

    // wide sum down to 16 bits; two folds suffice below 2^20
    function automatic logic [15:0] f_fold_wide(input logic [HDR_SUM_W-1:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[HDR_SUM_W-1:16]};
        f_fold_wide = f_fold17(t);
    endfunction

endpackage

FILE: src/tcs_in_if.sv
// Input channel of the TCP checksum generator: valid/ready plus item fields.
// No dependencies.
interface tcs_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] dest_address;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  flag_bits;
    logic [15:0] window;
    logic [15:0] urgent_pointer;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic [15:0] payload_word;
    logic        last_word;

    modport source (
        output valid, command, dest_address, seq_number, ack_number, flag_bits,
               window, urgent_pointer, source_port, dest_port, payload_length,
               payload_word, last_word,
        input  ready
    );

    modport sink (
        input  valid, command, dest_address, seq_number, ack_number, flag_bits,
               window, urgent_pointer, source_port, dest_port, payload_length,
               payload_word, last_word,
        output ready
    );
endinterface

FILE: src/tcs_out_if.sv
// Result channel of the TCP checksum generator: valid/ready plus checksum.
// No dependencies.
interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

FILE: src/tcs_sum_unit.sv
// Combinational checksum step: header or payload item against segment state.
// Depends on tcs_pkg.
module tcs_sum_unit
    import tcs_pkg::*;
(
    input  t_item       i_item,
    input  t_seg_state  i_state,
    input  logic [31:0] i_local_address,
    output t_seg_state  o_state,
    output t_result     o_result
);

    logic [HDR_SUM_W-1:0] hdr_wide;
    logic [15:0]          hdr_sum;
    logic [15:0]          tcp_length;
    logic [15:0]          offset_flags;
    logic [15:0]          word_masked;
    logic [15:0]          pay_sum;

    assign tcp_length   = TCP_HEADER_BYTES + i_item.payload_length;   // wraps mod 2^16
    assign offset_flags = ((DATA_OFFSET_WORDS & NIBBLE_MASK) << 12) | {8'd0, i_item.flag_bits};

    // pseudo-header plus header words, folded to 16 bits at the end
    assign hdr_wide = HDR_SUM_W'(i_local_address[31:16]) + HDR_SUM_W'(i_local_address[15:0])
                    + HDR_SUM_W'(i_item.dest_address[31:16])
                    + HDR_SUM_W'(i_item.dest_address[15:0])
                    + HDR_SUM_W'(IP_PROTO_TCP) + HDR_SUM_W'(tcp_length)
                    + HDR_SUM_W'(i_item.source_port) + HDR_SUM_W'(i_item.dest_port)
                    + HDR_SUM_W'(i_item.seq_number[31:16]) + HDR_SUM_W'(i_item.seq_number[15:0])
                    + HDR_SUM_W'(i_item.ack_number[31:16]) + HDR_SUM_W'(i_item.ack_number[15:0])
                    + HDR_SUM_W'(offset_flags) + HDR_SUM_W'(i_item.window)
                    + HDR_SUM_W'(i_item.urgent_pointer);
    assign hdr_sum = f_fold_wide(hdr_wide);

    // odd final byte padded with zero
    assign word_masked = (i_item.last_word && i_state.odd_length)
                       ? (i_item.payload_word & ODD_BYTE_MASK) : i_item.payload_word;
    assign pay_sum = f_fold17({1'b0, i_state.running_sum} + {1'b0, word_masked});

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.command)
            CMD_HEADER: begin
                o_state.running_sum = hdr_sum;
                if (i_item.payload_length == 16'd0) begin
                    o_state.odd_length = 1'b0;
                    o_state.in_segment = 1'b0;
                    o_result.valid     = 1'b1;
                    o_result.checksum  = ~hdr_sum;
                end else begin
                    o_state.odd_length = i_item.payload_length[0];
                    o_state.in_segment = 1'b1;
                end
            end
            CMD_PAYLOAD: begin
                if (i_state.in_segment) begin
                    o_state.running_sum = pay_sum;
                    if (i_item.last_word) begin
                        o_state.in_segment = 1'b0;
                        o_result.valid     = 1'b1;
                        o_result.checksum  = ~pay_sum;
                    end
                end
            end
            default: begin
                o_state  = i_state;
                o_result = '0;
            end
        endcase
    end

endmodule

FILE: src/tcp_checksum_generator_top.sv
// A result passes from the input transfer that completes it through the input
// register, then the sum logic, into the result register.
// Throughput: one item per cycle, header or payload; a stalled result only holds
// the input register when the waiting item would itself produce a checksum.
// Reset (i_rst_n low, synchronous): both channels empty, segment state cleared,
// local_address back to zero.
module tcp_checksum_generator_top
    import tcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcs_in_if.sink                i_in,
    tcs_out_if.source             o_out,
    // APB-style configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---- configuration ------------------------------------------------------
    logic [31:0] r_local_address;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_LOCAL_ADDR);
    assign prdata    = (paddr == REG_LOCAL_ADDR) ? r_local_address : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (cfg_write) begin
            r_local_address <= pwdata;
        end
    end

    // ---- input register -----------------------------------------------------
    // Holds one item; it moves on whenever its result (if any) has room.
    logic       r_in_valid;
    t_item      r_item;
    logic       in_xfer;
    logic       advance;

    t_seg_state r_state;
    t_seg_state n_state;
    t_result    step_res;

    logic        r_out_valid;
    logic [15:0] r_out_checksum;

    assign advance    = r_in_valid && (!step_res.valid || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.command        <= t_command'(i_in.command);
            r_item.dest_address   <= i_in.dest_address;
            r_item.seq_number     <= i_in.seq_number;
            r_item.ack_number     <= i_in.ack_number;
            r_item.flag_bits      <= i_in.flag_bits;
            r_item.window         <= i_in.window;
            r_item.urgent_pointer <= i_in.urgent_pointer;
            r_item.source_port    <= i_in.source_port;
            r_item.dest_port      <= i_in.dest_port;
            r_item.payload_length <= i_in.payload_length;
            r_item.payload_word   <= i_in.payload_word;
            r_item.last_word      <= i_in.last_word;
        end
    end

    // ---- sum logic and segment state ----------------------------------------
    tcs_sum_unit u_sum (
        .i_item          (r_item),
        .i_state         (r_state),
        .i_local_address (r_local_address),
        .o_state         (n_state),
        .o_result        (step_res)
    );

    // state only changes when the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // ---- result register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_checksum <= step_res.checksum;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.checksum = r_out_checksum;

endmodule

FILE: src/tcs_checker.sv
// Port-level checks for the TCP checksum generator, bound to the top level.
// Depends on tcs_pkg and tcp_checksum_generator_top.
module tcs_checker
    import tcs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [15:0]           i_out_checksum,
    input logic                  i_psel,
    input logic                  i_penable,
    input logic                  i_pwrite,
    input logic [APB_ADDR_W-1:0] i_paddr,
    input logic [APB_DATA_W-1:0] i_pwdata,
    input logic [APB_DATA_W-1:0] i_prdata
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // a new result needs a matching input transfer before it
    a_rise_needs_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching input transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_checksum))
        else $error("stalled result dropped or changed");

    // local address read back after a write
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr == REG_LOCAL_ADDR)
        |=> (i_paddr != REG_LOCAL_ADDR) || (i_prdata == $past(i_pwdata)))
        else $error("local address read-back mismatch");

endmodule

bind tcp_checksum_generator_top tcs_checker u_tcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_checksum (o_out.checksum),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);
